/* src/lcl_pkg.sv */
`timescale 1ns / 1ps

package lcl_pkg;

  // Width of a content identifier and of the running hit count.
  localparam int ID_W = 10;
  localparam int HIT_W = 32;

  // Default number of entries in the store.
  localparam int CAPACITY_DEFAULT = 64;

  // Stream data widths, padded up to whole bytes.
  localparam int S_DATA_W = 16;
  localparam int M_FIELDS_W = 2 + ID_W + HIT_W;
  localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

  // What one cell hands to the next one toward the least-recent end.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } link_t;

endpackage

/* src/lcl_cell.sv */
`timescale 1ns / 1ps

module lcl_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                hit,
  input  logic [lcl_pkg::ID_W-1:0] req_id,
  input  lcl_pkg::link_t      prev,
  output lcl_pkg::link_t      cur,
  input  logic                seen_in,
  output logic                seen_out
);
  import lcl_pkg::*;

  logic            valid;
  logic [ID_W-1:0] id;
  logic            match;
  logic            shift;

  assign match = valid && (id == req_id);

  // A match here or anywhere toward the least-recent end.
  assign seen_out = match | seen_in;

  // On a miss every cell shifts; on a hit only the cells from the head down
  // to the matching entry shift, which moves that entry to the head.
  assign shift = load && (!hit || seen_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      id <= prev.id;
    end
  end

  assign cur.valid = valid;
  assign cur.id    = id;

endmodule

/* src/lru_cache_lookup.sv */
`timescale 1ns / 1ps

// Fully associative cache of content identifiers in least-recently-used order.
// Requests arrive on the s_axis channel, one identifier per item. Each item
// yields exactly one result item on the m_axis channel: whether it hit,
// whether a miss pushed out the least-recent entry and which identifier that
// was, and the running hit count including this request (saturating).
// The store is a row of CAPACITY identical cells. Every cell compares its
// entry with the request at once; a match signal ripples from the tail toward
// the head, and the cells at or above the match (all cells on a miss) take
// their neighbor's entry in the same cycle, so the request lands at the head.
// A result is valid in the cycle after its request is accepted; one item per
// cycle is taken unless m_axis stalls. The result sits in an output register;
// s_axis_tready is high while that register is empty or being drained, so a
// stall on m_axis holds one finished result and stops further requests.
// Synchronous reset empties the store (all entries invalid), clears the hit
// count and drops the pending result; no clearing pass is needed.
module lru_cache_lookup #(
  parameter int CAPACITY = lcl_pkg::CAPACITY_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [9:0] content_id, [15:10] zero
  input  logic [lcl_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] hit, [1] evict_valid, [11:2] evicted_id, [43:12] hit_total, [47:44] zero
  output logic [lcl_pkg::M_DATA_W-1:0]  m_axis_tdata
);
  import lcl_pkg::*;

  logic             accept;
  logic [ID_W-1:0]  req_id;
  link_t            link [CAPACITY+1];
  logic             seen [CAPACITY+1];
  logic             hit;
  logic             evict_valid;
  logic [ID_W-1:0]  evicted_id;
  logic [HIT_W-1:0] hit_count;
  logic [HIT_W-1:0] hit_count_next;
  logic [M_DATA_W-1:0] out_data_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req_id        = s_axis_tdata[ID_W-1:0];

  // The head cell takes the request itself as a fresh valid entry.
  assign link[0].valid  = 1'b1;
  assign link[0].id     = req_id;
  assign seen[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lcl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (accept),
      .hit      (hit),
      .req_id   (req_id),
      .prev     (link[i]),
      .cur      (link[i+1]),
      .seen_in  (seen[i+1]),
      .seen_out (seen[i])
    );
  end

  assign hit = seen[0];

  // What falls off the tail on a miss is the evicted entry.
  assign evict_valid = !hit && link[CAPACITY].valid;
  assign evicted_id  = evict_valid ? link[CAPACITY].id : '0;

  assign hit_count_next = (hit && (hit_count != '1)) ? hit_count + 1'b1 : hit_count;

  assign out_data_next = {{(M_DATA_W - M_FIELDS_W){1'b0}},
                          hit_count_next, evicted_id, evict_valid, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        hit_count     <= hit_count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= out_data_next;
    end
  end

endmodule

/* src/lcl_chk.sv */
`timescale 1ns / 1ps

module lcl_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lcl_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import lcl_pkg::*;

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Every accepted request shows a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result one cycle after a request");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("hit reported together with an eviction");

  // Without an eviction the evicted identifier reads zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[ID_W+1:2] == '0)
    else $error("evicted identifier set without an eviction");

  // Reset drops any pending result.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind lru_cache_lookup lcl_chk u_lcl_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
